// ----- src/rc_serial_frame_receiver_top_assert.svh -----
// Assertion macros used by the serial frame receiver sequencer.
`ifndef RC_SERIAL_FRAME_RECEIVER_TOP_ASSERT_SVH
`define RC_SERIAL_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked on the module's clock and disabled in reset.
`define RCFR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcfr assertion failed");

// Next-cycle implication, checked on the module's clock and disabled in reset.
`define RCFR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcfr assertion failed");

`endif

// ----- src/rcfr_pkg.sv -----
// Constants and shared types of the serial frame receiver.
`default_nettype none
package rcfr_pkg;

   localparam int FrameBytes  = 32;
   localparam int NumChannels = (FrameBytes - 4) / 2;
   localparam int ByteW       = 8;
   localparam int ValueW      = 16;
   localparam int ChIdxW      = 5;
   localparam int FrameW      = FrameBytes * ByteW;
   localparam int SumCntW     = $clog2(FrameBytes);
   localparam int RotW        = $clog2(FrameBytes + 1);
   localparam int CsrIdxW     = 4;
   localparam int CsrDataW    = 8;

   localparam logic [ValueW-1:0] ChecksumGood = 16'hFFFF;
   localparam logic [ByteW-1:0]  HeaderFirstReset  = 8'd32;
   localparam logic [ByteW-1:0]  HeaderSecondReset = 8'd64;

   localparam logic [CsrIdxW-1:0] CSR_HEADER_FIRST  = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_HEADER_SECOND = 4'd1;

   // Commands from the sequencer to the frame datapath.
   typedef struct packed {
      logic shift_in;
      logic clear_acc;
      logic add_acc;
      logic add_high;
      logic rot_one;
      logic rot_two;
   } rcfr_ctl_type;

   // Status from the frame datapath to the sequencer.
   typedef struct packed {
      logic             frame_ok;
      logic [ByteW-1:0] low_byte;
      logic [ByteW-1:0] high_byte;
   } rcfr_sts_type;

endpackage
`default_nettype wire

// ----- src/rcfr_ifs.sv -----
// Valid/ready channel interfaces for received bytes and decoded channel words.
`default_nettype none
interface rcfr_req_if;
   import rcfr_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfr_rsp_if;
   import rcfr_pkg::*;
   logic              valid;
   logic              ready;
   logic [ChIdxW-1:0] channel_index;
   logic [ValueW-1:0] channel_value;
   logic              last_channel;
   modport source (output valid, output channel_index, output channel_value,
                   output last_channel, input ready);
   modport sink (input valid, input channel_index, input channel_value,
                 input last_channel, output ready);
endinterface
`default_nettype wire

// ----- src/rc_serial_frame_receiver_top.sv -----
// Each accepted byte is shifted into the window, then all FrameBytes bytes are summed and
// the frame is checked. A valid frame then emits its channel words, waiting while the
// output is held, and realigns the window; a rejected frame returns to idle. The shared adder
// walks the rotating frame one byte per cycle. No new byte is taken meanwhile.
// Reset (synchronous, active high) zeros the byte window and restores the headers
// to 0x20 and 0x40.
`default_nettype none
module rc_serial_frame_receiver_top (
   input  wire                         clock,
   input  wire                         reset,
   rcfr_req_if.sink                    req_bus,
   rcfr_rsp_if.source                  rsp_bus,
   input  wire                         csr_write_enable,
   input  wire [rcfr_pkg::CsrIdxW-1:0]  csr_index,
   input  wire [rcfr_pkg::CsrDataW-1:0] csr_write_data
);
   import rcfr_pkg::*;

   rcfr_ctl_type ctl;
   rcfr_sts_type sts;

   rcfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rx_byte          (req_bus.rx_byte),
      .ctl              (ctl),
      .sts              (sts)
   );

   rcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_index (rsp_bus.channel_index),
      .rsp_value (rsp_bus.channel_value),
      .rsp_last  (rsp_bus.last_channel),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule
`default_nettype wire

// ----- src/rcfr_datapath.sv -----
// Frame shift register, header registers and the shared checksum adder.
`default_nettype none
module rcfr_datapath (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_write_enable,
   input  wire [rcfr_pkg::CsrIdxW-1:0]  csr_index,
   input  wire [rcfr_pkg::CsrDataW-1:0] csr_write_data,
   input  wire [rcfr_pkg::ByteW-1:0]    rx_byte,
   input  wire rcfr_pkg::rcfr_ctl_type  ctl,
   output rcfr_pkg::rcfr_sts_type       sts
);
   import rcfr_pkg::*;

   // Byte k of the frame sits at bits [8k+7:8k]; byte 0 is the oldest.
   logic [FrameW-1:0] frm_ff, frm_in;
   logic [ValueW-1:0] acc_ff, acc_in;
   logic [ValueW-1:0] addend;
   logic [ByteW-1:0]  hdr_first_ff, hdr_first_in;
   logic [ByteW-1:0]  hdr_second_ff, hdr_second_in;

   always_comb begin
      frm_in = frm_ff;
      if (ctl.shift_in) begin
         frm_in = {rx_byte, frm_ff[FrameW-1:ByteW]};
      end else if (ctl.rot_two) begin
         frm_in = {frm_ff[2*ByteW-1:0], frm_ff[FrameW-1:2*ByteW]};
      end else if (ctl.rot_one) begin
         frm_in = {frm_ff[ByteW-1:0], frm_ff[FrameW-1:ByteW]};
      end
   end

   // The last byte of the frame is the high half of the checksum word.
   assign addend = ctl.add_high ? {frm_ff[ByteW-1:0], {ByteW{1'b0}}}
                                : {{ByteW{1'b0}}, frm_ff[ByteW-1:0]};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear_acc) begin
         acc_in = '0;
      end else if (ctl.add_acc) begin
         acc_in = acc_ff + addend;
      end
   end

   always_comb begin
      hdr_first_in  = hdr_first_ff;
      hdr_second_in = hdr_second_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HEADER_FIRST:  hdr_first_in  = csr_write_data[ByteW-1:0];
            CSR_HEADER_SECOND: hdr_second_in = csr_write_data[ByteW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_ff        <= '0;
         hdr_first_ff  <= HeaderFirstReset;
         hdr_second_ff <= HeaderSecondReset;
      end else begin
         frm_ff        <= frm_in;
         hdr_first_ff  <= hdr_first_in;
         hdr_second_ff <= hdr_second_in;
      end
      acc_ff <= acc_in;
   end

   assign sts.frame_ok  = (frm_ff[ByteW-1:0] == hdr_first_ff)
                       && (frm_ff[2*ByteW-1:ByteW] == hdr_second_ff)
                       && (acc_ff == ChecksumGood);
   assign sts.low_byte  = frm_ff[ByteW-1:0];
   assign sts.high_byte = frm_ff[2*ByteW-1:ByteW];

endmodule
`default_nettype wire

// ----- src/rcfr_ctrl.sv -----
// Sequencer: sums the frame through the shared adder, then emits channel words.
`default_nettype none
`include "rc_serial_frame_receiver_top_assert.svh"
module rcfr_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [rcfr_pkg::ChIdxW-1:0] rsp_index,
   output logic [rcfr_pkg::ValueW-1:0] rsp_value,
   output logic                       rsp_last,
   output rcfr_pkg::rcfr_ctl_type     ctl,
   input  wire rcfr_pkg::rcfr_sts_type sts
);
   import rcfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_EMIT,
      ST_RESTORE
   } state_type;

   state_type         state_ff, state_in;
   logic [SumCntW-1:0] cnt_ff, cnt_in;
   logic [RotW-1:0]    rot_ff, rot_in;
   logic [ChIdxW-1:0]  ch_ff, ch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ChIdxW-1:0]  rsp_index_ff, rsp_index_in;
   logic [ValueW-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               slot_free;
   logic               last_ch;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_ch   = (ch_ff == ChIdxW'(NumChannels - 1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rot_in       = rot_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.shift_in  = 1'b1;
               ctl.clear_acc = 1'b1;
               cnt_in        = '0;
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            // One frame byte per cycle; a full turn leaves the frame as it was.
            ctl.add_acc  = 1'b1;
            ctl.rot_one  = 1'b1;
            ctl.add_high = (cnt_ff == SumCntW'(FrameBytes - 1));
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == SumCntW'(FrameBytes - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.frame_ok) begin
               // Skip the two header bytes so the first channel word is in front.
               ctl.rot_two = 1'b1;
               rot_in      = RotW'(2);
               ch_in       = '0;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = ch_ff;
               rsp_value_in = {sts.high_byte, sts.low_byte};
               rsp_last_in  = last_ch;
               ctl.rot_two  = 1'b1;
               rot_in       = rot_ff + RotW'(2);
               ch_in        = ch_ff + 1'b1;
               if (last_ch) begin
                  state_in = ST_RESTORE;
               end
            end
         end
         ST_RESTORE: begin
            // Finish the turn so the window holds its bytes in order again.
            ctl.rot_one = 1'b1;
            rot_in      = rot_ff + 1'b1;
            if (rot_ff == RotW'(FrameBytes - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rot_ff       <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rot_ff       <= rot_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   `RCFR_ASSERT_NXT(a_accept_starts_sum, req_valid && req_ready, state_ff == ST_SUM && cnt_ff == '0)
   `RCFR_ASSERT_IMP(a_last_is_final, rsp_valid_ff && rsp_last_ff, rsp_index_ff == ChIdxW'(NumChannels - 1))
   `RCFR_ASSERT_IMP(a_turn_complete, state_ff == ST_RESTORE && state_in == ST_IDLE, rot_ff == RotW'(FrameBytes - 1))

endmodule
`default_nettype wire

// ----- verif/tb_rc_serial_frame_receiver_top.sv -----
// Self-checking testbench for the serial frame receiver: byte stream in, channel words out.
module tb_rc_serial_frame_receiver_top;
   import rcfr_pkg::*;

   localparam int SettleCycles  = 60;
   localparam int WatchdogLimit = 3000;
   localparam int LongHold      = 500;

   typedef struct packed {
      logic [ChIdxW-1:0] index;
      logic [ValueW-1:0] value;
      logic              last;
   } channel_word_type;

   typedef enum {FRAME_CLEAN, FRAME_BIT_FLIP, FRAME_WRONG_HEADER} frame_fault_type;
   typedef enum {DRAIN_ALWAYS, DRAIN_RANDOM, DRAIN_PATTERN} drain_mode_type;

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_write_data;

   rcfr_req_if req_bus ();
   rcfr_rsp_if rsp_bus ();

   rc_serial_frame_receiver_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: the last FrameBytes-1 bytes, oldest first, and the header registers.
   logic [ByteW-1:0] rx_window [FrameBytes-1];
   logic [ByteW-1:0] hdr_first;
   logic [ByteW-1:0] hdr_second;
   channel_word_type pending_channels [$];

   int             errors = 0;
   int             burst_left = 0;
   bit             sender_gaps = 1'b0;
   drain_mode_type drain_mode = DRAIN_ALWAYS;
   int             hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void predict_channels(input logic [ByteW-1:0] rx);
      logic [ByteW-1:0] frame [FrameBytes];
      logic [ValueW-1:0] sum;
      channel_word_type word;
      for (int k = 0; k < FrameBytes - 1; k++) frame[k] = rx_window[k];
      frame[FrameBytes-1] = rx;
      sum = '0;
      for (int k = 0; k < FrameBytes - 2; k++) sum += frame[k];
      sum += {frame[FrameBytes-1], frame[FrameBytes-2]};
      if (frame[0] == hdr_first && frame[1] == hdr_second && sum == ChecksumGood) begin
         for (int c = 0; c < NumChannels; c++) begin
            word.index = c[ChIdxW-1:0];
            word.value = {frame[3+2*c], frame[2+2*c]};
            word.last  = (c == NumChannels - 1);
            pending_channels.push_back(word);
         end
      end
      for (int k = 0; k < FrameBytes - 1; k++) rx_window[k] = frame[k+1];
   endfunction

   task automatic check_channel_word();
      channel_word_type want;
      if (pending_channels.size() == 0) begin
         errors++;
         $display("%0t: unexpected channel word: index %0d value %h last %0b", $time,
                  rsp_bus.channel_index, rsp_bus.channel_value, rsp_bus.last_channel);
      end else begin
         want = pending_channels.pop_front();
         if (rsp_bus.channel_index !== want.index) begin
            errors++;
            $display("%0t: channel_index expected %0d actual %0d", $time,
                     want.index, rsp_bus.channel_index);
         end
         if (rsp_bus.channel_value !== want.value) begin
            errors++;
            $display("%0t: channel_value expected %h actual %h", $time,
                     want.value, rsp_bus.channel_value);
         end
         if (rsp_bus.last_channel !== want.last) begin
            errors++;
            $display("%0t: last_channel expected %0b actual %0b", $time,
                     want.last, rsp_bus.last_channel);
         end
      end
   endtask

   // Receiver: checks every accepted word and decides ready for the next cycle.
   initial begin
      int hold_left;
      int tick;
      hold_left = 0;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_channel_word();
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            case (drain_mode)
               DRAIN_ALWAYS: rsp_bus.ready <= 1'b1;
               DRAIN_RANDOM: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default:      rsp_bus.ready <= ((tick % 5) != 2) && ((tick % 11) < 8);
            endcase
         end
      end
   end

   // Watchdog: ends the run when neither channel moves a word for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: timeout, %0d channel words still expected", $time,
                     pending_channels.size());
            $display("rc_serial_frame_receiver_top regression: fail");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] rx);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (sender_gaps) gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= rx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_channels(rx);
      burst_left--;
   endtask

   task automatic send_frame(input logic [ByteW-1:0] h1, input logic [ByteW-1:0] h2,
                             input frame_fault_type fault,
                             input logic [ValueW-1:0] channels [NumChannels]);
      logic [ByteW-1:0] bytes [FrameBytes];
      logic [ValueW-1:0] sum;
      int pos;
      int bit_pos;
      bytes[0] = h1;
      bytes[1] = h2;
      for (int c = 0; c < NumChannels; c++) begin
         bytes[2+2*c] = channels[c][7:0];
         bytes[3+2*c] = channels[c][15:8];
      end
      // With an odd frame length one summed byte sits before the checksum.
      for (int k = 2 + 2 * NumChannels; k < FrameBytes - 2; k++) bytes[k] = ByteW'($urandom);
      if (fault == FRAME_WRONG_HEADER) begin
         pos = $urandom_range(0, 1);
         bytes[pos] ^= ByteW'($urandom_range(1, 255));
      end
      sum = '0;
      for (int k = 0; k < FrameBytes - 2; k++) sum += bytes[k];
      sum = ChecksumGood - sum;
      bytes[FrameBytes-2] = sum[7:0];
      bytes[FrameBytes-1] = sum[15:8];
      if (fault == FRAME_BIT_FLIP) begin
         pos = $urandom_range(0, FrameBytes - 1);
         bit_pos = $urandom_range(0, ByteW - 1);
         bytes[pos][bit_pos] = ~bytes[pos][bit_pos];
      end
      for (int k = 0; k < FrameBytes; k++) send_byte(bytes[k]);
   endtask

   function automatic void fill_random_channels(output logic [ValueW-1:0] channels [NumChannels]);
      for (int c = 0; c < NumChannels; c++) channels[c] = ValueW'($urandom);
   endfunction

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_HEADER_FIRST)
         hdr_first = data;
      else if (idx == CSR_HEADER_SECOND)
         hdr_second = data;
      @(posedge clock);
   endtask

   // Waits until every expected word has arrived, then lets a rejected byte finish too.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_channels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic test_ignored_index();
      logic [CsrIdxW-1:0] idx;
      for (int n = 0; n < 4; n++) begin
         idx = CsrIdxW'($urandom_range(CSR_HEADER_SECOND + 1, (1 << CsrIdxW) - 1));
         write_csr(idx, CsrDataW'($urandom));
      end
   endtask

   // The reset headers must still hold; the zero window takes part in the first checks.
   task automatic test_reset_defaults();
      logic [ValueW-1:0] channels [NumChannels];
      for (int c = 0; c < NumChannels; c++) begin
         case (c % 4)
            0: channels[c] = 16'h0000;
            1: channels[c] = 16'hFFFF;
            2: channels[c] = 16'h00FF;
            default: channels[c] = 16'hFF00;
         endcase
      end
      send_frame(HeaderFirstReset, HeaderSecondReset, FRAME_CLEAN, channels);
      wait_idle();
   endtask

   task automatic run_random_phase(input logic [ByteW-1:0] h1, input logic [ByteW-1:0] h2,
                                   input int target, input drain_mode_type mode,
                                   input bit gaps);
      logic [ValueW-1:0] channels [NumChannels];
      int sent;
      int pick;
      int noise_len;
      write_csr(CSR_HEADER_FIRST, h1);
      write_csr(CSR_HEADER_SECOND, h2);
      drain_mode = mode;
      sender_gaps = gaps;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            fill_random_channels(channels);
            if (pick < 5)
               send_frame(h1, h2, FRAME_CLEAN, channels);
            else if (pick < 7)
               send_frame(h1, h2, FRAME_BIT_FLIP, channels);
            else
               send_frame(h1, h2, FRAME_WRONG_HEADER, channels);
            sent += FrameBytes;
         end else begin
            // Noise ahead of a frame; zero runs matter when the headers are zero.
            noise_len = $urandom_range(1, 6);
            for (int k = 0; k < noise_len; k++)
               send_byte($urandom_range(0, 1) ? ByteW'($urandom) : '0);
            sent += noise_len;
         end
      end
      wait_idle();
   endtask

   task automatic test_header_extremes();
      run_random_phase(8'h00, 8'h00, 20, DRAIN_ALWAYS, 1'b0);
      run_random_phase(8'hFF, 8'hFF, 20, DRAIN_RANDOM, 1'b1);
   endtask

   task automatic test_random_headers();
      run_random_phase(ByteW'($urandom), ByteW'($urandom), 20, DRAIN_PATTERN, 1'b1);
      run_random_phase(ByteW'($urandom), 8'h00, 20, DRAIN_RANDOM, 1'b1);
   endtask

   // The receiver holds off for a long stretch while frames keep coming in.
   task automatic test_backpressure();
      logic [ValueW-1:0] channels [NumChannels];
      drain_mode = DRAIN_RANDOM;
      sender_gaps = 1'b0;
      hold_request = LongHold;
      for (int n = 0; n < 2; n++) begin
         fill_random_channels(channels);
         send_frame(hdr_first, hdr_second, FRAME_CLEAN, channels);
      end
      wait_idle();
   endtask

   initial begin
      for (int k = 0; k < FrameBytes - 1; k++) rx_window[k] = '0;
      hdr_first  = HeaderFirstReset;
      hdr_second = HeaderSecondReset;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.rx_byte  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_index();
      test_reset_defaults();
      test_header_extremes();
      test_random_headers();
      test_backpressure();

      if (errors == 0 && pending_channels.size() == 0)
         $display("rc_serial_frame_receiver_top regression: pass");
      else
         $display("rc_serial_frame_receiver_top regression: fail");
      $finish;
   end

endmodule
